@@ design/pli_pkg.sv @@
// shared constants, codes and types of the piecewise linear interpolator
package pli_pkg;

  // table depth default and field widths
  localparam int MaxPointsDef = 16;
  localparam int CountW       = 5;
  localparam int StrainW      = 32;
  localparam int StressW      = 32;
  localparam int SlopeW       = 48;
  localparam int StatusW      = 3;
  localparam int IndexW       = 4;

  // slope is (dy << SlopeFrac) / dx, kept to DivBits quotient bits before saturation
  localparam int SlopeFrac = 28;
  localparam int DivBits   = SlopeW - 1;
  localparam int SatShift  = DivBits - SlopeFrac;
  localparam int QuotPad   = DivBits - StrainW;
  localparam int DivStepW  = 6;

  localparam logic [DivStepW-1:0] QuotSteps  = DivStepW'(StrainW);
  localparam logic [DivStepW-1:0] SlopeSteps = DivStepW'(DivBits);

  localparam logic [SlopeW-1:0] SlopePosMax = {1'b0, {DivBits{1'b1}}};
  localparam logic [SlopeW-1:0] SlopeNegMin = {1'b1, {DivBits{1'b0}}};

  // command codes
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // status codes
  localparam logic [StatusW-1:0] StatusOk       = 3'd0;
  localparam logic [StatusW-1:0] StatusLow      = 3'd1;
  localparam logic [StatusW-1:0] StatusHigh     = 3'd2;
  localparam logic [StatusW-1:0] StatusZeroSpan = 3'd3;
  localparam logic [StatusW-1:0] StatusEmpty    = 3'd4;

  // request to the serial divider
  typedef struct packed {
    logic                start;
    logic [StrainW-1:0]  divisor;
    logic [StrainW-1:0]  rem;
    logic [DivBits-1:0]  bits;
    logic [DivStepW-1:0] steps;
  } div_req_t;

endpackage

@@ design/pli_div.sv @@
// restoring serial divider, one quotient bit per cycle
module pli_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pli_pkg::div_req_t                  req,
  output logic                               done,
  output logic [pli_pkg::DivBits-1:0]        quo
);

  localparam logic [pli_pkg::DivStepW-1:0] DivStepOne = pli_pkg::DivStepW'(1);

  logic [pli_pkg::StrainW-1:0]  dsr_r;
  logic [pli_pkg::StrainW-1:0]  rem_r;
  logic [pli_pkg::DivBits-1:0]  bits_r;
  logic [pli_pkg::DivBits-1:0]  quo_r;
  logic [pli_pkg::DivStepW-1:0] cnt_r;
  logic                         busy_r;
  logic                         done_r;

  logic [pli_pkg::StrainW:0]    partial;
  logic [pli_pkg::StrainW+1:0]  diff;
  logic                         ge;

  // trial subtract of the divisor from the shifted partial remainder
  assign partial = {rem_r, bits_r[pli_pkg::DivBits-1]};
  assign diff    = {1'b0, partial} - {2'b00, dsr_r};
  assign ge      = ~diff[pli_pkg::StrainW+1];

  // sequencing: load on start, count down the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DivStepOne) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder, dividend bits and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      dsr_r  <= req.divisor;
      rem_r  <= req.rem;
      bits_r <= req.bits;
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[pli_pkg::StrainW-1:0] : partial[pli_pkg::StrainW-1:0];
      bits_r <= {bits_r[pli_pkg::DivBits-2:0], 1'b0};
      quo_r  <= {quo_r[pli_pkg::DivBits-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ design/piecewise_linear_interpolator_core.sv @@
// Piecewise linear interpolator: a breakpoint table (strain Q4.28, stress Q20.12) loaded by
// write items, and queries that return the interpolated stress and the segment slope (Q36.12,
// saturated). One item is handled at a time. A write, or a query on an empty table, goes
// straight to its result. A query scans the table one entry per cycle through the table's
// single read port; an interior query then uses the shared serial divider, which runs 32
// steps for the stress and 47 for the slope (the slope pass is skipped when it saturates).
// Table entries hold no reset value and must be written before a query reads them.
// The finished result waits in an output register, so a new item is taken while it is pending.
module piecewise_linear_interpolator_core #(
  parameter int MAX_POINTS = pli_pkg::MaxPointsDef
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic [pli_pkg::IndexW-1:0]         in_point_index,
  input  logic [pli_pkg::StrainW-1:0]        in_point_strain,
  input  logic [pli_pkg::StressW-1:0]        in_point_stress,
  input  logic [pli_pkg::StrainW-1:0]        in_query_strain,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pli_pkg::StressW-1:0]        out_stress_value,
  output logic signed [pli_pkg::SlopeW-1:0]  out_hardening_slope,
  output logic [pli_pkg::StatusW-1:0]        out_status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pli_pkg::CountW-1:0]         cfg_point_count
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_SEG  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_DQS  = 4'd4;
  localparam logic [3:0] S_DQW  = 4'd5;
  localparam logic [3:0] S_DSS  = 4'd6;
  localparam logic [3:0] S_DSW  = 4'd7;
  localparam logic [3:0] S_CALC = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state_r, state_nxt;

  logic [pli_pkg::StrainW-1:0] strain_mem_r [MAX_POINTS];
  logic [pli_pkg::StressW-1:0] stress_mem_r [MAX_POINTS];
  logic [pli_pkg::StrainW-1:0] rd_strain_r;
  logic [pli_pkg::StressW-1:0] rd_stress_r;
  logic [IW-1:0]               rd_addr;

  logic [pli_pkg::CountW-1:0]  count_r;
  logic [IW-1:0]               idx_r;
  logic [IW-1:0]               last_r;
  logic [pli_pkg::StrainW-1:0] q_r;
  logic [pli_pkg::StrainW-1:0] s0_r, s1_r, dx_r, dq_r;
  logic [pli_pkg::StressW-1:0] y0_r, y1_r, mag_r;
  logic                        neg_r;
  logic                        sat_r;
  logic [2*pli_pkg::StrainW-1:0] prod_r;
  logic [pli_pkg::StressW-1:0] quot_r;
  logic [pli_pkg::DivBits-1:0] sq_r;

  logic [pli_pkg::StressW-1:0] res_stress_r;
  logic [pli_pkg::SlopeW-1:0]  res_slope_r;
  logic [pli_pkg::StatusW-1:0] res_status_r;

  logic                        out_valid_r;
  logic [pli_pkg::StressW-1:0] out_stress_r;
  logic [pli_pkg::SlopeW-1:0]  out_slope_r;
  logic [pli_pkg::StatusW-1:0] out_status_r;

  logic in_xfer, out_free, found, wr_in_range, count_clamp;
  logic [IW-1:0] last_w;

  pli_pkg::div_req_t           div_req;
  logic                        div_done;
  logic [pli_pkg::DivBits-1:0] div_quo;

  assign in_ready    = (state_r == S_IDLE);
  assign in_xfer     = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign found       = (q_r <= rd_strain_r);
  assign wr_in_range = (32'(in_point_index) < MAX_POINTS);
  assign count_clamp = (32'(count_r) >= MAX_POINTS);
  assign last_w      = count_clamp ? IW'(MAX_POINTS - 1) : IW'(count_r - 1'b1);

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_r <= cfg_point_count;
    end
  end

  // breakpoint table, written by write items
  always_ff @(posedge clk) begin
    if (in_xfer && in_cmd == pli_pkg::CmdWrite && wr_in_range) begin
      strain_mem_r[IW'(in_point_index)] <= in_point_strain;
      stress_mem_r[IW'(in_point_index)] <= in_point_stress;
    end
  end

  // read address runs one entry ahead of the compare
  assign rd_addr = (state_r == S_SRCH) ? idx_r + 1'b1 : '0;

  always_ff @(posedge clk) begin
    rd_strain_r <= strain_mem_r[rd_addr];
    rd_stress_r <= stress_mem_r[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_cmd == pli_pkg::CmdWrite || count_r == '0) state_nxt = S_FIN;
          else                                              state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (found)                state_nxt = (idx_r == '0) ? S_FIN : S_SEG;
        else if (idx_r == last_r) state_nxt = S_FIN;
      end
      S_SEG:  state_nxt = (s1_r <= s0_r) ? S_FIN : S_MUL;
      S_MUL:  state_nxt = S_DQS;
      S_DQS:  state_nxt = S_DQW;
      S_DQW:  if (div_done) state_nxt = sat_r ? S_CALC : S_DSS;
      S_DSS:  state_nxt = S_DSW;
      S_DSW:  if (div_done) state_nxt = S_CALC;
      S_CALC: state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // divider requests: stress quotient, then slope quotient
  always_comb begin
    div_req = '0;
    div_req.divisor = dx_r;
    if (state_r == S_DQS) begin
      div_req.start = 1'b1;
      div_req.rem   = prod_r[2*pli_pkg::StrainW-1:pli_pkg::StrainW];
      div_req.bits  = {prod_r[pli_pkg::StrainW-1:0], {pli_pkg::QuotPad{1'b0}}};
      div_req.steps = pli_pkg::QuotSteps;
    end else if (state_r == S_DSS) begin
      div_req.start = 1'b1;
      div_req.rem   = mag_r >> pli_pkg::SatShift;
      div_req.bits  = {mag_r[pli_pkg::SatShift-1:0], {pli_pkg::SlopeFrac{1'b0}}};
      div_req.steps = pli_pkg::SlopeSteps;
    end
  end

  pli_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_ready)               out_valid_r <= 1'b0;
    end
  end

  // search, segment setup and result datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          q_r          <= in_query_strain;
          idx_r        <= '0;
          last_r       <= last_w;
          res_stress_r <= '0;
          res_slope_r  <= '0;
          if (in_cmd == pli_pkg::CmdQuery && count_r == '0) res_status_r <= pli_pkg::StatusEmpty;
          else                                              res_status_r <= pli_pkg::StatusOk;
        end
      end
      S_SRCH: begin
        if (found) begin
          s1_r <= rd_strain_r;
          y1_r <= rd_stress_r;
          if (idx_r == '0) begin
            res_stress_r <= rd_stress_r;
            res_slope_r  <= '0;
            res_status_r <= pli_pkg::StatusLow;
          end
        end else begin
          s0_r  <= rd_strain_r;
          y0_r  <= rd_stress_r;
          idx_r <= idx_r + 1'b1;
          if (idx_r == last_r) begin
            res_stress_r <= rd_stress_r;
            res_slope_r  <= '0;
            res_status_r <= pli_pkg::StatusHigh;
          end
        end
      end
      S_SEG: begin
        if (s1_r <= s0_r) begin
          res_stress_r <= y0_r;
          res_slope_r  <= '0;
          res_status_r <= pli_pkg::StatusZeroSpan;
        end
        dx_r  <= s1_r - s0_r;
        dq_r  <= q_r - s0_r;
        neg_r <= (y1_r < y0_r);
        mag_r <= (y1_r < y0_r) ? y0_r - y1_r : y1_r - y0_r;
      end
      S_MUL: begin
        prod_r <= mag_r * dq_r;
        sat_r  <= ((mag_r >> pli_pkg::SatShift) >= dx_r);
      end
      S_DQW: if (div_done) quot_r <= div_quo[pli_pkg::StressW-1:0];
      S_DSW: if (div_done) sq_r <= div_quo;
      S_CALC: begin
        res_status_r <= pli_pkg::StatusOk;
        if (neg_r) begin
          res_stress_r <= y0_r - quot_r;
          res_slope_r  <= sat_r ? pli_pkg::SlopeNegMin : pli_pkg::SlopeW'(0) - {1'b0, sq_r};
        end else begin
          res_stress_r <= y0_r + quot_r;
          res_slope_r  <= sat_r ? pli_pkg::SlopePosMax : {1'b0, sq_r};
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_stress_r <= res_stress_r;
      out_slope_r  <= res_slope_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_stress_value    = out_stress_r;
  assign out_hardening_slope = out_slope_r;
  assign out_status          = out_status_r;

endmodule

@@ design/pli_checker.sv @@
// port level checks of the interpolator, bound to the top level
module pli_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [pli_pkg::StressW-1:0]        out_stress_value,
  input logic signed [pli_pkg::SlopeW-1:0]  out_hardening_slope,
  input logic [pli_pkg::StatusW-1:0]        out_status
);

  // a pending result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_stress_value)
      && $stable(out_hardening_slope) && $stable(out_status))
    else $error("result changed while stalled");

  // one item at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // every clamped or flagged result carries a zero slope
  a_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pli_pkg::StatusOk |-> out_hardening_slope == '0)
    else $error("nonzero slope on a flagged result");

  // an empty table gives zero stress
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pli_pkg::StatusEmpty |-> out_stress_value == '0)
    else $error("nonzero stress on empty table");

  // no result right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind piecewise_linear_interpolator_core pli_checker u_pli_checker (.*);

@@ test/testbench.sv @@
// testbench for the piecewise linear interpolator core: breakpoint tables, queries, point counts
`timescale 1ns / 1ps

module testbench;

  // one result of the block, as predicted or as seen on the output
  typedef struct packed {
    logic [pli_pkg::StressW-1:0] stress;
    logic [pli_pkg::SlopeW-1:0]  slope;
    logic [pli_pkg::StatusW-1:0] status;
  } lookup_result_t;

  // table predictor plus the queue of lookups still owed by the block
  class interp_scoreboard;
    logic [pli_pkg::StrainW-1:0] strain_tab[pli_pkg::MaxPointsDef];
    logic [pli_pkg::StressW-1:0] stress_tab[pli_pkg::MaxPointsDef];
    logic [pli_pkg::CountW-1:0]  point_count;
    lookup_result_t     owed_results[$];
    int mismatches;
    int checked;
    int writes;
    int queries;
    int status_hits[8];

    function new();
      point_count = '0;
      mismatches  = 0;
      checked     = 0;
      writes      = 0;
      queries     = 0;
      foreach (status_hits[k]) status_hits[k] = 0;
    endfunction

    function void set_count(logic [pli_pkg::CountW-1:0] c);
      point_count = c;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // an accepted input transfer: update the table or work out the lookup
    function void note_transfer(logic cmd, logic [pli_pkg::IndexW-1:0] idx,
                                logic [pli_pkg::StrainW-1:0] ps,
                                logic [pli_pkg::StressW-1:0] py,
                                logic [pli_pkg::StrainW-1:0] q);
      lookup_result_t r;
      int n;
      int k;
      logic [pli_pkg::StrainW-1:0] s0, s1;
      logic [pli_pkg::StressW-1:0] y0, y1;
      logic [63:0] dx, dq, mag, quot, smag;
      r.stress = '0;
      r.slope  = '0;
      r.status = pli_pkg::StatusOk;
      if (cmd == pli_pkg::CmdWrite) begin
        writes++;
        if (int'(idx) < pli_pkg::MaxPointsDef) begin
          strain_tab[idx] = ps;
          stress_tab[idx] = py;
        end
      end else begin
        queries++;
        // counts past the table depth act as a full table
        n = (int'(point_count) > pli_pkg::MaxPointsDef) ? pli_pkg::MaxPointsDef
                                                         : int'(point_count);
        k = 0;
        while (k < n && q > strain_tab[k]) k++;
        if (n == 0) begin
          r.status = pli_pkg::StatusEmpty;
        end else if (k == n) begin
          r.stress = stress_tab[n-1];
          r.status = pli_pkg::StatusHigh;
        end else if (k == 0) begin
          r.stress = stress_tab[0];
          r.status = pli_pkg::StatusLow;
        end else begin
          s0 = strain_tab[k-1];
          s1 = strain_tab[k];
          y0 = stress_tab[k-1];
          y1 = stress_tab[k];
          if (s1 <= s0) begin
            // guard only, the first-match search never lands here
            r.stress = y0;
            r.status = pli_pkg::StatusZeroSpan;
          end else begin
            dx   = 64'(s1 - s0);
            dq   = 64'(q - s0);
            mag  = (y1 < y0) ? 64'(y0 - y1) : 64'(y1 - y0);
            quot = (mag * dq) / dx;
            smag = (mag << pli_pkg::SlopeFrac) / dx;
            // round toward the left breakpoint, saturate the slope
            if (y1 < y0) begin
              if (smag > 64'(pli_pkg::SlopeNegMin)) smag = 64'(pli_pkg::SlopeNegMin);
              r.stress = y0 - quot[pli_pkg::StressW-1:0];
              r.slope  = -smag[pli_pkg::SlopeW-1:0];
            end else begin
              if (smag > 64'(pli_pkg::SlopePosMax)) smag = 64'(pli_pkg::SlopePosMax);
              r.stress = y0 + quot[pli_pkg::StressW-1:0];
              r.slope  = smag[pli_pkg::SlopeW-1:0];
            end
          end
        end
        status_hits[r.status]++;
      end
      owed_results.push_back(r);
    endfunction

    // a result transfer: compare with the oldest owed lookup
    function void check_result(logic [pli_pkg::StressW-1:0] stress,
                               logic [pli_pkg::SlopeW-1:0] slope,
                               logic [pli_pkg::StatusW-1:0] status);
      lookup_result_t e;
      checked++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none owed: stress=%h slope=%0d status=%0d",
                   $time, stress, $signed(slope), status);
      end else begin
        e = owed_results.pop_front();
        if (e.stress !== stress || e.slope !== slope || e.status !== status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch exp stress=%h slope=%0d status=%0d",
                     $time, e.stress, $signed(e.slope), e.status);
            $display("%0t: mismatch got stress=%h slope=%0d status=%0d",
                     $time, stress, $signed(slope), status);
          end
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_cmd = pli_pkg::CmdWrite;
  logic [pli_pkg::IndexW-1:0]    in_point_index = '0;
  logic [pli_pkg::StrainW-1:0]   in_point_strain = '0;
  logic [pli_pkg::StressW-1:0]   in_point_stress = '0;
  logic [pli_pkg::StrainW-1:0]   in_query_strain = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [pli_pkg::StressW-1:0]   out_stress_value;
  logic signed [pli_pkg::SlopeW-1:0] out_hardening_slope;
  logic [pli_pkg::StatusW-1:0]   out_status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [pli_pkg::CountW-1:0]    cfg_point_count = '0;

  interp_scoreboard sb = new();

  // stimulus-side copy of the table strains, used to aim queries
  logic [pli_pkg::StrainW-1:0] tab_strain[pli_pkg::MaxPointsDef];
  logic [pli_pkg::CountW-1:0]  cur_count = '0;
  bit                 quiet = 1'b0;
  int                 n_settings = 0;

  piecewise_linear_interpolator_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_point_index      (in_point_index),
    .in_point_strain     (in_point_strain),
    .in_point_stress     (in_point_stress),
    .in_query_strain     (in_query_strain),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_stress_value    (out_stress_value),
    .out_hardening_slope (out_hardening_slope),
    .out_status          (out_status),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_point_count     (cfg_point_count)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one input transfer; valid stays up across back-to-back items
  task automatic drive_item(input logic cmd, input logic [pli_pkg::IndexW-1:0] idx,
                            input logic [pli_pkg::StrainW-1:0] ps,
                            input logic [pli_pkg::StressW-1:0] py,
                            input logic [pli_pkg::StrainW-1:0] q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_point_index  <= idx;
    in_point_strain <= ps;
    in_point_stress <= py;
    in_query_strain <= q;
    do @(posedge clk); while (!in_ready);
    sb.note_transfer(cmd, idx, ps, py, q);
  endtask

  task automatic write_point(input int idx, input logic [pli_pkg::StrainW-1:0] s,
                             input logic [pli_pkg::StressW-1:0] y);
    tab_strain[idx] = s;
    drive_item(pli_pkg::CmdWrite, pli_pkg::IndexW'(idx), s, y, $urandom);
  endtask

  task automatic query(input logic [pli_pkg::StrainW-1:0] q);
    drive_item(pli_pkg::CmdQuery, pli_pkg::IndexW'($urandom), $urandom, $urandom, q);
  endtask

  // point count write, only once every owed result is out
  task automatic set_count(input logic [pli_pkg::CountW-1:0] c);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_point_count <= c;
    do @(posedge clk); while (!cfg_ready);
    sb.set_count(c);
    cur_count = c;
    n_settings++;
    cfg_valid <= 1'b0;
  endtask

  // fresh strictly increasing table, written in shuffled slot order
  task automatic load_table(input int gap_mode, input int level_mode);
    logic [pli_pkg::StrainW-1:0] s[pli_pkg::MaxPointsDef];
    logic [pli_pkg::StressW-1:0] y[pli_pkg::MaxPointsDef];
    logic [63:0] total;
    int lim, j, t;
    int order[pli_pkg::MaxPointsDef];
    case (gap_mode)
      0: lim = 8;
      1: lim = 'h1000;
      default: lim = 'h0F00_0000;
    endcase
    total = 0;
    for (int k = 1; k < pli_pkg::MaxPointsDef; k++) begin
      s[k] = $urandom_range(1, lim);
      total += s[k];
    end
    if (gap_mode == 3) s[0] = pli_pkg::StrainW'(64'hFFFF_FFFF - total);
    else if (gap_mode == 4) s[0] = '0;
    else s[0] = $urandom_range(0, lim);
    for (int k = 1; k < pli_pkg::MaxPointsDef; k++) s[k] = s[k-1] + s[k];
    // stress shapes: anything, nearly flat, rising
    y[0] = (level_mode == 2) ? pli_pkg::StressW'($urandom_range(0, 'h0FFF_FFFF))
                             : pli_pkg::StressW'($urandom);
    for (int k = 1; k < pli_pkg::MaxPointsDef; k++) begin
      case (level_mode)
        0: y[k] = $urandom;
        1: y[k] = y[0] + pli_pkg::StressW'($urandom_range(0, 63)) - 32;
        default: y[k] = y[k-1] + pli_pkg::StressW'($urandom_range(0, 'h00FF_FFFF));
      endcase
    end
    for (int k = 0; k < pli_pkg::MaxPointsDef; k++) order[k] = k;
    for (int k = pli_pkg::MaxPointsDef - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < pli_pkg::MaxPointsDef; k++)
      write_point(order[k], s[order[k]], y[order[k]]);
  endtask

  // query strain aimed at segments, breakpoints and the ends of the range
  function automatic logic [pli_pkg::StrainW-1:0] pick_query();
    int n, k, r;
    logic [pli_pkg::StrainW-1:0] lo, hi;
    n = (int'(cur_count) > pli_pkg::MaxPointsDef) ? pli_pkg::MaxPointsDef : int'(cur_count);
    r = $urandom_range(0, 99);
    if (n == 0 || r >= 80) return $urandom;
    k = $urandom_range(0, n - 1);
    if (r < 45 && k > 0) begin
      lo = tab_strain[k-1];
      hi = tab_strain[k];
      if (hi > lo) return lo + 1 + pli_pkg::StrainW'($urandom_range(0, hi - lo - 1));
      return $urandom;
    end
    if (r < 65) return tab_strain[k] + pli_pkg::StrainW'($urandom_range(0, 2)) - 1;
    if (r < 72) return '0;
    return '1;
  endfunction

  // result side: random stalls, check each result transfer
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result(out_stress_value, out_hardening_slope, out_status);
      if (stall_left != 0) stall_left--;
      else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      out_ready <= (stall_left == 0);
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [pli_pkg::CountW-1:0] c;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty table right after reset
    query('0);
    query('1);

    // directed table: saturating rising and falling segments, zero and full stress
    for (int k = 0; k < pli_pkg::MaxPointsDef; k++) begin
      if (k < 3) write_point(k, pli_pkg::StrainW'('h100 + k), (k == 1) ? '1 : '0);
      else write_point(k, pli_pkg::StrainW'(k * 'h0800_0000 + 'h123), $urandom);
    end
    set_count(5'd16);
    query('0);
    query(tab_strain[0]);
    query(tab_strain[1]);
    query(tab_strain[2]);
    query(tab_strain[3] - 'h0123_4567);
    query(tab_strain[15]);
    query('1);

    // random phases, each with its own table and point count
    for (int p = 0; p < 11; p++) begin
      quiet = ($urandom_range(0, 3) == 0);
      load_table($urandom_range(0, 4), $urandom_range(0, 2));
      case (p)
        0: c = 5'd16;
        1: c = 5'd1;
        2: c = 5'd2;
        3: c = 5'd31;
        4: c = 5'd17;
        5: c = 5'd0;
        6: c = pli_pkg::CountW'($urandom_range(3, 15));
        8: c = pli_pkg::CountW'($urandom_range(0, 31));
        9: c = 5'd15;
        default: c = 5'd16;
      endcase
      set_count(c);
      repeat (112) begin
        if ($urandom_range(0, 9) == 0)
          write_point($urandom_range(0, pli_pkg::MaxPointsDef - 1), $urandom, $urandom);
        else
          query(pick_query());
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // drain, then keep watching the output for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    $display("run: %0d breakpoint writes, %0d queries, %0d point count settings, %0d results",
             sb.writes, sb.queries, n_settings, sb.checked);
    $display("queries: %0d interpolated, %0d below table, %0d above table, %0d empty table",
             sb.status_hits[pli_pkg::StatusOk], sb.status_hits[pli_pkg::StatusLow],
             sb.status_hits[pli_pkg::StatusHigh], sb.status_hits[pli_pkg::StatusEmpty]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
